// ===== hw/rtl/smma_pkg.sv =====
// Package with types and constants shared by the matrix multiply-accumulate block.
`timescale 1ns / 1ps
`default_nettype none
package smma_pkg;

	// Function codes of an input word.
	typedef enum logic [1:0] {
		FUNC_LOAD_A = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_LOAD_C = 2'd2,
		FUNC_COMPUTE = 2'd3
	} func_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_ROWS_M = 3'd0;
	localparam logic [2:0] REG_COLS_N = 3'd1;
	localparam logic [2:0] REG_INNER_K = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_BETA = 3'd4;

	localparam int FRAC_BITS = 8;
	localparam int SCALE_BITS = 16;
	localparam int DIM_BITS = 4;
	localparam int IDX_BITS = 3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Control handed from the sequencer to the cell row.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/smma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/smma_cell.sv =====
// One multiply-accumulate cell: forms A times B for its column of C and passes A on.
`timescale 1ns / 1ps
`default_nettype none
module smma_cell #(
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS = 38
) (
	input wire logic clk,
	input wire smma_pkg::cell_ctrl_t ctrl,
	input wire logic a_valid,
	input wire logic signed [ELEM_BITS-1:0] a_in,
	input wire logic signed [ELEM_BITS-1:0] b_in,
	output logic a_valid_out,
	output logic signed [ELEM_BITS-1:0] a_out,
	output logic signed [ACC_BITS-1:0] acc,
	input wire logic signed [ACC_BITS-1:0] acc_shift_in
);
	import smma_pkg::*;

	logic signed [2*ELEM_BITS-1:0] prod;
	logic signed [ACC_BITS-1:0] acc_q;

	assign prod = a_in * b_in;

	// Pass the A element to the neighbour and accumulate; shift results out when asked.
	always_ff @(posedge clk) begin
		a_out <= a_in;
		a_valid_out <= a_valid;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.shift) begin
			acc_q <= acc_shift_in;
		end else if (a_valid) begin
			acc_q <= acc_q + ACC_BITS'(prod);
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/smma_row.sv =====
// Row of cells, one per column of C, with A flowing from cell to cell.
`timescale 1ns / 1ps
`default_nettype none
module smma_row #(
	parameter int MAX_DIM = 8,
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS = 38
) (
	input wire logic clk,
	input wire smma_pkg::cell_ctrl_t ctrl,
	input wire logic a_valid,
	input wire logic signed [ELEM_BITS-1:0] a_in,
	input wire logic signed [MAX_DIM*ELEM_BITS-1:0] b_row,
	output logic signed [ACC_BITS-1:0] acc_head
);
	import smma_pkg::*;

	logic v_chain [MAX_DIM+1];
	logic signed [ELEM_BITS-1:0] a_chain [MAX_DIM+1];
	logic signed [ACC_BITS-1:0] acc_chain [MAX_DIM+1];

	assign v_chain[0] = a_valid;
	assign a_chain[0] = a_in;
	assign acc_chain[MAX_DIM] = '0;
	assign acc_head = acc_chain[0];

	// Cell c works on column c; B element c is delayed so it meets A in cell c.
	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		logic signed [ELEM_BITS-1:0] b_dly [c+1];
		assign b_dly[0] = b_row[c*ELEM_BITS +: ELEM_BITS];
		for (genvar d = 1; d <= c; d++) begin : g_dly
			logic signed [ELEM_BITS-1:0] b_q;
			always_ff @(posedge clk) begin
				b_q <= b_dly[d-1];
			end
			assign b_dly[d] = b_q;
		end
		smma_cell #(.ELEM_BITS(ELEM_BITS), .ACC_BITS(ACC_BITS)) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.a_valid(v_chain[c]),
			.a_in(a_chain[c]),
			.b_in(b_dly[c]),
			.a_valid_out(v_chain[c+1]),
			.a_out(a_chain[c+1]),
			.acc(acc_chain[c]),
			.acc_shift_in(acc_chain[c+1])
		);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/scaled_matrix_multiply_accumulate.sv =====
// Top level of the scaled matrix multiply-accumulate block, C = alpha*A*B + beta*C.
//
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, func, row_index, col_index, elem_value
// out     | output    | out_valid, out_ready, out_row, out_col, out_value, overflow, last
// config  | input     | cfg_we, cfg_index, cfg_data
//
// A compute word runs each row of C through the row of cells: it feeds and drains
// the row in the feed state, then takes each element through three scaling phases
// and one emit state.
// Reset clears control state only; the stores hold nothing defined until loaded.
// A stalled output holds the sequencer; inputs wait while a compute word runs.
`timescale 1ns / 1ps
`default_nettype none
module scaled_matrix_multiply_accumulate #(
	parameter int MAX_DIM = 8,
	parameter int ELEM_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] func,
	input wire logic [2:0] row_index,
	input wire logic [2:0] col_index,
	input wire logic signed [15:0] elem_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] out_row,
	output logic [2:0] out_col,
	output logic signed [15:0] out_value,
	output logic overflow,
	output logic last,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import smma_pkg::*;

	localparam int AW = 6;
	localparam int ACC_BITS = 2 * ELEM_BITS + 6;
	localparam int SUM_BITS = ACC_BITS + SCALE_BITS + 2;
	localparam int CW = 5;

	// Configuration registers.
	logic [DIM_BITS-1:0] rows_m_q, cols_n_q, inner_k_q;
	logic signed [SCALE_BITS-1:0] alpha_q, beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q <= DIM_BITS'(8);
			cols_n_q <= DIM_BITS'(8);
			inner_k_q <= DIM_BITS'(8);
			alpha_q <= SCALE_BITS'(256);
			beta_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_M: rows_m_q <= cfg_data[DIM_BITS-1:0];
				REG_COLS_N: cols_n_q <= cfg_data[DIM_BITS-1:0];
				REG_INNER_K: inner_k_q <= cfg_data[DIM_BITS-1:0];
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA: beta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped dimensions.
	logic [DIM_BITS-1:0] m_eff, n_eff, k_eff;
	assign m_eff = (rows_m_q > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : rows_m_q;
	assign n_eff = (cols_n_q > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : cols_n_q;
	assign k_eff = (inner_k_q > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : inner_k_q;

	// Sequencer registers.
	state_t state_q, state_d;
	logic [IDX_BITS-1:0] i_q, i_d;
	logic [DIM_BITS-1:0] j_q, j_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0] ph_q, ph_d;
	logic ovalid_q, ovalid_d;

	logic load_acc;
	logic is_load;
	assign is_load = (func_t'(func) != FUNC_COMPUTE);
	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// Loads outside the stores in use are dropped.
	logic load_ok;
	assign load_ok = ({1'b0, row_index} < DIM_BITS'(MAX_DIM)) &&
		({1'b0, col_index} < DIM_BITS'(MAX_DIM));

	// A store: read one row element per cycle while feeding.
	logic [AW-1:0] a_raddr, c_addr_r, c_waddr;
	logic [IDX_BITS-1:0] b_raddr;
	logic signed [ELEM_BITS-1:0] a_rd, c_rd;
	logic [MAX_DIM*ELEM_BITS-1:0] b_rd;
	logic signed [ELEM_BITS-1:0] wval;
	logic c_we_res;
	logic signed [ELEM_BITS-1:0] res_val;

	assign wval = ELEM_BITS'(elem_value);
	assign a_raddr = {i_q, cnt_q[IDX_BITS-1:0]};
	assign b_raddr = cnt_q[IDX_BITS-1:0];

	smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(64)) u_a_ram (
		.clk(clk),
		.we(in_fire && load_ok && func_t'(func) == FUNC_LOAD_A),
		.waddr({row_index, col_index}),
		.wdata(wval),
		.raddr(a_raddr),
		.rdata(a_rd)
	);

	// B store as one RAM per column, so a whole row of B is read at once.
	for (genvar c = 0; c < MAX_DIM; c++) begin : g_bram
		logic [ELEM_BITS-1:0] bq;
		smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(1 << IDX_BITS)) u_b_ram (
			.clk(clk),
			.we(in_fire && load_ok && func_t'(func) == FUNC_LOAD_B &&
				col_index == IDX_BITS'(c)),
			.waddr(row_index),
			.wdata(wval),
			.raddr(b_raddr),
			.rdata(bq)
		);
		assign b_rd[c*ELEM_BITS +: ELEM_BITS] = bq;
	end

	// C store: loads and write-backs share the write port.
	assign c_addr_r = {i_q, j_q[IDX_BITS-1:0]};
	assign c_waddr = c_we_res ? c_addr_r : {row_index, col_index};
	smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(64)) u_c_ram (
		.clk(clk),
		.we(c_we_res || (in_fire && load_ok && func_t'(func) == FUNC_LOAD_C)),
		.waddr(c_waddr),
		.wdata(c_we_res ? res_val : wval),
		.raddr(c_addr_r),
		.rdata(c_rd)
	);

	// Feed valid is registered so that it lines up with the registered A read.
	logic feed_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= 1'b0;
		end else begin
			feed_s1 <= (state_q == ST_FEED) && (cnt_q < CW'(k_eff));
		end
	end

	// Row of cells.
	cell_ctrl_t ctrl;
	logic signed [ACC_BITS-1:0] acc_head;
	smma_row #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS), .ACC_BITS(ACC_BITS)) u_row (
		.clk(clk),
		.ctrl(ctrl),
		.a_valid(feed_s1),
		.a_in(a_rd),
		.b_row(b_rd),
		.acc_head(acc_head)
	);

	// Scaling datapath: alpha*sum in phase 0, beta*C in phase 1, combine in phase 2.
	logic signed [ACC_BITS+SCALE_BITS-1:0] ap_q;
	logic signed [2*ELEM_BITS-1:0] bc_q;
	logic signed [SUM_BITS-1:0] tot;
	logic signed [SUM_BITS-1:0] shifted;
	logic signed [ELEM_BITS-1:0] vmax, vmin;
	logic ovf;

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && ph_q == 2'd0) begin
			ap_q <= acc_head * alpha_q;
		end
		if (state_q == ST_FINISH && ph_q == 2'd1) begin
			bc_q <= c_rd * beta_q;
		end
	end

	assign tot = SUM_BITS'(ap_q) + (SUM_BITS'(bc_q) <<< FRAC_BITS);
	assign shifted = tot >>> (2 * FRAC_BITS);
	assign vmax = {1'b0, {(ELEM_BITS-1){1'b1}}};
	assign vmin = {1'b1, {(ELEM_BITS-1){1'b0}}};
	always_comb begin
		if (shifted > SUM_BITS'(vmax)) begin
			res_val = vmax;
			ovf = 1'b1;
		end else if (shifted < SUM_BITS'(vmin)) begin
			res_val = vmin;
			ovf = 1'b1;
		end else begin
			res_val = ELEM_BITS'(shifted);
			ovf = 1'b0;
		end
	end

	// Output register.
	logic [2:0] orow_q, ocol_q;
	logic signed [15:0] oval_q;
	logic oovf_q, olast_q;
	always_ff @(posedge clk) begin
		if (load_acc) begin
			orow_q <= i_q;
			ocol_q <= j_q[IDX_BITS-1:0];
			oval_q <= 16'(res_val);
			oovf_q <= ovf;
			olast_q <= (DIM_BITS'(i_q) + 1'b1 == m_eff) && (j_q + 1'b1 == n_eff);
		end
	end
	assign out_valid = ovalid_q;
	assign out_row = orow_q;
	assign out_col = ocol_q;
	assign out_value = oval_q;
	assign overflow = oovf_q;
	assign last = olast_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			ph_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			cnt_q <= cnt_d;
			ph_q <= ph_d;
			ovalid_q <= ovalid_d;
		end
	end

	// Next state: feed a row, drain it, then scale and emit each element from the head.
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		cnt_d = cnt_q;
		ph_d = ph_q;
		ovalid_d = ovalid_q && !out_ready;
		ctrl = '0;
		load_acc = 1'b0;
		c_we_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !is_load && m_eff != '0 && n_eff != '0) begin
					state_d = ST_FEED;
					i_d = '0;
					j_d = '0;
					cnt_d = '0;
					ctrl.clear = 1'b1;
				end
			end
			ST_FEED: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CW'(k_eff) + CW'(MAX_DIM) + CW'(1)) begin
					state_d = ST_FINISH;
					ph_d = '0;
					j_d = '0;
				end
			end
			ST_FINISH: begin
				ph_d = ph_q + 1'b1;
				if (ph_q == 2'd2) begin
					if (!ovalid_q || out_ready) begin
						load_acc = 1'b1;
						c_we_res = 1'b1;
						ovalid_d = 1'b1;
						ph_d = '0;
						ctrl.shift = 1'b1;
						state_d = ST_EMIT;
					end else begin
						ph_d = ph_q;
					end
				end
			end
			ST_EMIT: begin
				if (j_q + 1'b1 == n_eff) begin
					j_d = '0;
					if (DIM_BITS'(i_q) + 1'b1 == m_eff) begin
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
						cnt_d = '0;
						ctrl.clear = 1'b1;
						state_d = ST_FEED;
					end
				end else begin
					j_d = j_q + 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	// No new word is taken while a compute run is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input accepted during compute");
	// A waiting result is never overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
		else $error("pending result lost");
	// The run ends after the element marked last.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_d == ST_IDLE) |=> last)
		else $error("run ended without last mark");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the scaled matrix multiply-accumulate block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import smma_pkg::*;

	localparam int DIM = 8;
	localparam int SETTLE_CYCLES = 700;

	// One emitted C element as the block should produce it.
	typedef struct {
		logic [2:0] row;
		logic [2:0] col;
		logic [15:0] value;
		logic ovf;
		logic last;
	} c_word_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [2:0] row_index;
	logic [2:0] col_index;
	logic signed [15:0] elem_value;
	logic out_valid;
	logic out_ready;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic signed [15:0] out_value;
	logic overflow;
	logic last;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// Shadow copy of the stores and registers used by the predictor.
	logic signed [15:0] a_mat [DIM*DIM];
	logic signed [15:0] b_mat [DIM*DIM];
	logic signed [15:0] c_mat [DIM*DIM];
	logic [3:0] m_dim, n_dim, k_dim;
	logic signed [15:0] alpha_q, beta_q;

	c_word_t pending_c [$];
	int mismatches;
	bit quiet;

	scaled_matrix_multiply_accumulate u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .row_index(row_index), .col_index(col_index),
		.elem_value(elem_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_row(out_row), .out_col(out_col), .out_value(out_value),
		.overflow(overflow), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out every C element of one compute word and updates the shadow C.
	task automatic predict_gemm();
		int m, n, k;
		longint acc, res;
		c_word_t w;
		m = (m_dim > DIM) ? DIM : m_dim;
		n = (n_dim > DIM) ? DIM : n_dim;
		k = (k_dim > DIM) ? DIM : k_dim;
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = (longint'(beta_q) * longint'(c_mat[i*DIM+j])) <<< FRAC_BITS;
				for (int l = 0; l < k; l++)
					acc += longint'(alpha_q) *
						(longint'(a_mat[i*DIM+l]) * longint'(b_mat[l*DIM+j]));
				res = acc >>> (2 * FRAC_BITS);
				w.ovf = 1'b0;
				if (res > 32767) begin
					res = 32767;
					w.ovf = 1'b1;
				end else if (res < -32768) begin
					res = -32768;
					w.ovf = 1'b1;
				end
				w.row = i[2:0];
				w.col = j[2:0];
				w.value = res[15:0];
				w.last = (i == m - 1) && (j == n - 1);
				c_mat[i*DIM+j] = res[15:0];
				pending_c.push_back(w);
			end
		end
	endtask

	// Sends one input word and applies it to the predictor once accepted.
	task automatic send_word(input func_t f, input int r, input int c, input int v);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row_index <= r[2:0];
		col_index <= c[2:0];
		elem_value <= v[15:0];
		do @(posedge clk); while (!in_ready);
		case (f)
			FUNC_LOAD_A: a_mat[r*DIM+c] = v[15:0];
			FUNC_LOAD_B: b_mat[r*DIM+c] = v[15:0];
			FUNC_LOAD_C: c_mat[r*DIM+c] = v[15:0];
			default: predict_gemm();
		endcase
	endtask

	// Holds the sender until every expected element has been emitted.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_c.size() != 0) @(posedge clk);
	endtask

	// Register write, only once the block is idle; a compute with no
	// result may still be running, so a settling pause comes first.
	task automatic write_reg(input logic [2:0] idx, input int value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROWS_M: m_dim = value[3:0];
			REG_COLS_N: n_dim = value[3:0];
			REG_INNER_K: k_dim = value[3:0];
			REG_ALPHA: alpha_q = value[15:0];
			default: beta_q = value[15:0];
		endcase
	endtask

	function automatic int rand_elem();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 1023) - 512;
		return $urandom_range(0, 65535) - 32768;
	endfunction

	function automatic int rand_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(9, 15);
			2: return 8;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	// Every store entry is written before any compute can read it.
	task automatic test_fill_stores();
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++) begin
				send_word(FUNC_LOAD_A, r, c, rand_elem());
				send_word(FUNC_LOAD_B, r, c, rand_elem());
				send_word(FUNC_LOAD_C, r, c, rand_elem());
			end
	endtask

	// Field extremes, scale extremes and the dimension corner cases.
	task automatic test_directed();
		send_word(FUNC_LOAD_A, 0, 0, 32767);
		send_word(FUNC_LOAD_B, 0, 0, -32768);
		send_word(FUNC_LOAD_A, 7, 7, -32768);
		send_word(FUNC_LOAD_B, 7, 7, -32768);
		send_word(FUNC_LOAD_C, 7, 0, 32767);
		send_word(FUNC_COMPUTE, 0, 0, 0);
		write_reg(REG_ALPHA, 16'h8000);
		write_reg(REG_BETA, 16'h7fff);
		send_word(FUNC_COMPUTE, 7, 7, 0);
		// Zero rows: the compute word emits nothing and leaves C alone.
		write_reg(REG_ROWS_M, 0);
		send_word(FUNC_COMPUTE, 0, 0, 0);
		// Dimensions above the store size act as the full size.
		write_reg(REG_ROWS_M, 15);
		write_reg(REG_COLS_N, 9);
		write_reg(REG_INNER_K, 0);
		write_reg(REG_ALPHA, 256);
		write_reg(REG_BETA, 16'hff00);
		send_word(FUNC_COMPUTE, 0, 0, 0);
		write_reg(REG_COLS_N, 0);
		send_word(FUNC_COMPUTE, 0, 0, 0);
		write_reg(REG_ROWS_M, 1);
		write_reg(REG_COLS_N, 1);
		write_reg(REG_INNER_K, 1);
		write_reg(REG_BETA, 0);
		send_word(FUNC_COMPUTE, 0, 0, 0);
	endtask

	// Random loads with computes among them, reconfigured from time to time.
	task automatic test_random(input int words);
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_ROWS_M, rand_dim());
					write_reg(REG_COLS_N, rand_dim());
					write_reg(REG_INNER_K, rand_dim());
					write_reg(REG_ALPHA, ($urandom_range(0, 2) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(0, 511) - 256);
					write_reg(REG_BETA, ($urandom_range(0, 2) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(0, 511) - 256);
				end
				send_word(FUNC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 65535));
			end else begin
				send_word(func_t'($urandom_range(0, 2)), $urandom_range(0, 7),
					$urandom_range(0, 7), rand_elem());
			end
		end
	endtask

	// The sender waits for the whole result set before going on.
	task automatic test_pause_for_results();
		send_word(FUNC_COMPUTE, 0, 0, 0);
		drain_results();
		send_word(FUNC_LOAD_C, 3, 4, -1);
		send_word(FUNC_COMPUTE, 0, 0, 0);
	endtask

	// Receiver stalls come in random bursts unless the run is in its quiet part.
	int stall_left;
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Each accepted element is checked against the oldest expectation.
	always @(posedge clk) begin
		c_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_c.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected C word row %0d col %0d value %h",
						out_row, out_col, out_value);
			end else begin
				w = pending_c.pop_front();
				if (out_row !== w.row || out_col !== w.col || out_value !== w.value ||
						overflow !== w.ovf || last !== w.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("C word mismatch: expected r%0d c%0d %h ovf %b last %b, got r%0d c%0d %h ovf %b last %b",
							w.row, w.col, w.value, w.ovf, w.last,
							out_row, out_col, out_value, overflow, last);
				end
			end
		end
	end

	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD_A;
		row_index = '0;
		col_index = '0;
		elem_value = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS_M;
		cfg_data = '0;
		stall_left = 0;
		mismatches = 0;
		quiet = 1'b0;
		m_dim = 4'd8;
		n_dim = 4'd8;
		k_dim = 4'd8;
		alpha_q = 16'sd256;
		beta_q = 16'sd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_directed();
		test_random(110);
		test_pause_for_results();
		quiet = 1'b1;
		test_random(35);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_c.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
